// File: rtl/blrf_pkg.sv
// shared types and constants for the load record framer
package blrf_pkg;

	// record type bytes
	localparam logic [7:0] TYPE_DATA_RECORD = 8'h0D;
	localparam logic [7:0] TYPE_END_RECORD  = 8'h0E;

	// largest number of bytes one item can cause
	localparam int MAX_BYTES = 9;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);

	// configuration register indexes
	localparam logic REG_ENTRY_ADDRESS   = 1'b0;
	localparam logic REG_INITIAL_ADDRESS = 1'b1;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_DATA  = 2'd1,
		FUNC_END   = 2'd2
	} func_t;

	// bytes caused by one item, handed to the output shifter
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      done;
	} frame_t;

endpackage

// File: rtl/blrf_if.sv
// item channels of the load record framer
interface blrf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  data_byte;
	logic [15:0] record_length;
	logic        load_address;
	logic [31:0] new_address;

	modport source (output valid, func, data_byte, record_length, load_address, new_address,
		input ready);
	modport sink (input valid, func, data_byte, record_length, load_address, new_address,
		output ready);
endinterface

interface blrf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       record_done;

	modport source (output valid, out_byte, run_last, record_done, input ready);
	modport sink (input valid, out_byte, run_last, record_done, output ready);
endinterface

// File: rtl/binary_load_record_framer_unit.sv
// top level of the load record framer
// Frames a download byte stream into load records. A start item emits the
// 0x0D header (address and length, LSB first), each data item passes its byte
// and after the last byte of a record the 16-bit byte sum follows; an end item
// emits 0x0E and the entry address. Each item is decoded in the cycle it is
// accepted and its bytes go to an output shift register that sends one byte a
// cycle while the receiver is ready. An item causes 1 byte for a plain data
// byte, 3 for the closing data byte, 7 for a start (9 for an empty record)
// and 5 for an end; an item causing no bytes loads nothing into the shifter.
// The next item is accepted in the cycle its predecessor's last byte leaves.
module binary_load_record_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	blrf_in_if.sink     item_in,
	blrf_out_if.source  rec_out
);

	logic [31:0]        entry_address_q;
	logic [31:0]        initial_address_q;
	logic [31:0]        running_address_q;
	logic [15:0]        bytes_left_q;
	logic [15:0]        byte_sum_q;
	logic               record_open_q;
	logic [15:0]        record_size_q;

	logic               cfg_wr;
	logic               accept;
	logic               free;
	blrf_pkg::frame_t   frame;
	logic [31:0]        start_addr;
	logic [15:0]        sum_next;
	logic [15:0]        left_next;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == blrf_pkg::REG_INITIAL_ADDRESS) ? initial_address_q
		: entry_address_q;

	assign item_in.ready = free;
	assign accept        = item_in.valid && free;

	assign start_addr = item_in.load_address ? item_in.new_address : running_address_q;
	assign sum_next   = byte_sum_q + {8'd0, item_in.data_byte};
	assign left_next  = bytes_left_q - 16'd1;

	// bytes caused by the item at the input
	always_comb begin
		frame.bytes = '0;
		frame.count = '0;
		frame.done  = 1'b0;
		case (item_in.func)
			blrf_pkg::FUNC_START: begin
				frame.bytes[0] = blrf_pkg::TYPE_DATA_RECORD;
				frame.bytes[1] = start_addr[7:0];
				frame.bytes[2] = start_addr[15:8];
				frame.bytes[3] = start_addr[23:16];
				frame.bytes[4] = start_addr[31:24];
				frame.bytes[5] = item_in.record_length[7:0];
				frame.bytes[6] = item_in.record_length[15:8];
				if (item_in.record_length == 16'd0) begin
					// empty record: zero sum follows the header
					frame.count = blrf_pkg::CNT_W'(9);
					frame.done  = 1'b1;
				end else begin
					frame.count = blrf_pkg::CNT_W'(7);
				end
			end
			blrf_pkg::FUNC_DATA: begin
				if (record_open_q) begin
					frame.bytes[0] = item_in.data_byte;
					frame.bytes[1] = sum_next[7:0];
					frame.bytes[2] = sum_next[15:8];
					if (left_next == 16'd0) begin
						frame.count = blrf_pkg::CNT_W'(3);
						frame.done  = 1'b1;
					end else begin
						frame.count = blrf_pkg::CNT_W'(1);
					end
				end
			end
			blrf_pkg::FUNC_END: begin
				frame.bytes[0] = blrf_pkg::TYPE_END_RECORD;
				frame.bytes[1] = entry_address_q[7:0];
				frame.bytes[2] = entry_address_q[15:8];
				frame.bytes[3] = entry_address_q[23:16];
				frame.bytes[4] = entry_address_q[31:24];
				frame.count    = blrf_pkg::CNT_W'(5);
				frame.done     = 1'b1;
			end
			default: begin
				frame.count = '0;
			end
		endcase
	end

	// registers and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_address_q   <= '0;
			initial_address_q <= '0;
			running_address_q <= '0;
			bytes_left_q      <= '0;
			byte_sum_q        <= '0;
			record_open_q     <= 1'b0;
			record_size_q     <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == blrf_pkg::REG_INITIAL_ADDRESS) begin
				initial_address_q <= pwdata;
				running_address_q <= pwdata;
			end else begin
				entry_address_q <= pwdata;
			end
		end else if (accept) begin
			case (item_in.func)
				blrf_pkg::FUNC_START: begin
					running_address_q <= start_addr;
					record_size_q     <= item_in.record_length;
					bytes_left_q      <= item_in.record_length;
					byte_sum_q        <= '0;
					record_open_q     <= (item_in.record_length != 16'd0);
				end
				blrf_pkg::FUNC_DATA: begin
					if (record_open_q) begin
						byte_sum_q   <= sum_next;
						bytes_left_q <= left_next;
						if (left_next == 16'd0) begin
							running_address_q <= running_address_q + {16'd0, record_size_q};
							record_open_q     <= 1'b0;
						end
					end
				end
				blrf_pkg::FUNC_END: begin
					record_open_q <= 1'b0;
					bytes_left_q  <= '0;
				end
				default: begin
					record_open_q <= record_open_q;
				end
			endcase
		end
	end

	blrf_shifter u_shifter (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept && (frame.count != '0)),
		.frame   (frame),
		.free    (free),
		.rec_out (rec_out)
	);

	// an open record always expects at least one more byte
	a_open_left: assert property (@(posedge clk) disable iff (!arst_n)
		record_open_q |-> (bytes_left_q != 16'd0))
		else $error("open record with no bytes left");

	// an accepted end item closes the record
	a_end_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_wr && (item_in.func == blrf_pkg::FUNC_END)) |=> !record_open_q)
		else $error("record still open after end item");

	// a data byte with no open record leaves the address alone
	a_stray_data: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_wr && !record_open_q && (item_in.func == blrf_pkg::FUNC_DATA))
		|=> $stable(running_address_q))
		else $error("address moved on a stray data byte");

endmodule

// File: rtl/blrf_shifter.sv
// output shift register that sends the bytes of one item in order
module blrf_shifter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  blrf_pkg::frame_t    frame,
	output logic                free,
	blrf_out_if.source          rec_out
);

	logic [blrf_pkg::MAX_BYTES-1:0][7:0] bytes_q;
	logic [blrf_pkg::CNT_W-1:0]          rem_q;
	logic                                done_q;
	logic                                busy;
	logic                                last;
	logic                                fire;

	// handshake and end of item
	assign busy  = (rem_q != '0);
	assign last  = (rem_q == blrf_pkg::CNT_W'(1));
	assign fire  = rec_out.valid && rec_out.ready;
	assign free  = !busy || (fire && last);

	assign rec_out.valid       = busy;
	assign rec_out.out_byte    = bytes_q[0];
	assign rec_out.run_last    = last;
	assign rec_out.record_done = last && done_q;

	// remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= frame.count;
		end else if (fire) begin
			rem_q <= rem_q - blrf_pkg::CNT_W'(1);
		end
	end

	// byte payload, shifted down as bytes leave
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= frame.bytes;
			done_q  <= frame.done;
		end else if (fire) begin
			for (int i = 0; i < blrf_pkg::MAX_BYTES - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

	// a new item never lands on bytes still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("item loaded while shifter holds unsent bytes");

	// a loaded item brings at least one byte
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (frame.count != '0))
		else $error("empty item loaded into shifter");

	// the last byte sent with nothing new leaves the shifter idle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last && !load) |=> !rec_out.valid)
		else $error("shifter still busy after last byte");

	// count only falls by one on a sent byte
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !fire && !load) |=> $stable(rem_q))
		else $error("remaining count moved without a sent byte");

endmodule
